@@ sv/tsf_pkg.sv @@
package tsf_pkg;

  // Datapath widths that do not follow the module parameters.
  localparam int OP_W    = 64;   // operand register, holds any state or scaled sample
  localparam int HALF_W  = 32;   // operand half fed to the multiplier
  localparam int COEF_W  = 32;
  localparam int PROD_W  = COEF_W + HALF_W + 1;
  localparam int ACC_W   = 100;

  // Microprogram length and step counter width.
  localparam int NUM_STEPS = 33;
  localparam int STEP_W    = 6;

  // Configuration register indexes.
  localparam logic [1:0] REG_RATE_MODE = 2'd0;
  localparam logic [1:0] REG_GAIN_ONE  = 2'd1;
  localparam logic [1:0] REG_GAIN_TWO  = 2'd2;
  localparam logic [1:0] REG_GAIN_THREE = 2'd3;

  // Codes of the rate_mode register; the spare code runs the rate one hundred table.
  typedef enum logic [1:0] {
    RATE_FIVE,
    RATE_TWENTY_FIVE,
    RATE_HUNDRED,
    RATE_SPARE
  } rate_e;

  // Coefficient sources: 0 to 11 index the A and B table (B starts at SRC_B0), 12 to 14 the C gains.
  localparam logic [3:0] SRC_B0    = 4'd9;
  localparam logic [3:0] SRC_GAIN0 = 4'd12;
  localparam logic [3:0] SRC_GAIN1 = 4'd13;
  localparam logic [3:0] SRC_GAIN2 = 4'd14;

  typedef enum logic [1:0] {
    COND_NONE,
    COND_IN,
    COND_OUT
  } cond_e;

  typedef enum logic [2:0] {
    OPND_X0,
    OPND_X1,
    OPND_X2,
    OPND_UX,
    OPND_N0,
    OPND_N1,
    OPND_N2
  } opnd_e;

  typedef struct packed {
    logic       load;
    logic       mul;
    logic [3:0] src;
    opnd_e      opnd;
    logic       hi;
    logic       clr;
    logic       rnd_st;
    logic [1:0] rnd_idx;
    logic       rnd_out;
    logic       commit;
    cond_e      cond;
    logic       last;
  } ctrl_t;

  typedef struct packed {
    logic in_valid;
    logic out_free;
  } stat_t;

  // a11 a12 a13 a21 a22 a23 a31 a32 a33 b1 b2 b3 in signed Q1.31.
  localparam logic signed [COEF_W-1:0] COEF_R5 [12] = '{
    32'sd1332077980, -32'sd594464280, -32'sd692973453,
    32'sd692973453, 32'sd2025051432, -32'sd149468381,
    32'sd74734191, 32'sd421220917, 32'sd2137152718,
    32'sd346486726, 32'sd74734191, 32'sd5165465
  };
  localparam logic signed [COEF_W-1:0] COEF_R25 [12] = '{
    32'sd1977404063, -32'sd127074237, -32'sd164972575,
    32'sd164972575, 32'sd2142376638, -32'sd6689612,
    32'sd3344806, 32'sd85831094, 32'sd2147393847,
    32'sd82486288, 32'sd3344806, 32'sd44900
  };
  localparam logic signed [COEF_W-1:0] COEF_R100 [12] = '{
    32'sd2104641354, -32'sd32103988, -32'sd42520892,
    32'sd42520892, 32'sd2147162246, -32'sd426637,
    32'sd213318, 32'sd21473765, 32'sd2147482223,
    32'sd21260446, 32'sd213318, 32'sd712
  };

  // Table lookup; the unused mode code falls back to the rate one hundred table.
  function automatic logic signed [COEF_W-1:0] coef_pick(logic [1:0] mode, logic [3:0] idx);
    logic signed [COEF_W-1:0] c;
    c = '0;
    if (idx < SRC_GAIN0) begin
      case (mode)
        RATE_FIVE:        c = COEF_R5[idx];
        RATE_TWENTY_FIVE: c = COEF_R25[idx];
        default:          c = COEF_R100[idx];
      endcase
    end
    return c;
  endfunction

  // Microprogram. Each product takes a low-half and a high-half multiply step.
  // The product register and the accumulator each add a stage, so a sum is
  // rounded once its last product has passed both, while the next sum starts.
  function automatic ctrl_t ucode(logic [STEP_W-1:0] step);
    ctrl_t w;
    int s;
    int p;
    int h;
    int i;
    int k;
    w = '0;
    s = int'(step);
    p = 0;
    h = 0;
    i = 0;
    k = 0;
    if (s == 0) begin
      w.load = 1'b1;
      w.cond = COND_IN;
    end else if (s <= 30) begin
      p = (s - 1) >> 1;
      h = (s - 1) & 1;
      w.mul = 1'b1;
      w.hi  = (h == 1);
      if (p < 12) begin
        i = p >> 2;
        k = p & 3;
        if (k == 0) begin
          w.src  = 4'(int'(SRC_B0) + i);
          w.opnd = OPND_UX;
        end else begin
          w.src  = 4'(3 * i + k - 1);
          w.opnd = opnd_e'(3'(k - 1));
        end
        w.clr = (k == 0) && (h == 0);
      end else begin
        w.src  = 4'(int'(SRC_GAIN0) + p - 12);
        w.opnd = opnd_e'(3'(int'(OPND_N0) + p - 12));
        w.clr  = (p == 12) && (h == 0);
      end
    end
    if (s == 10 || s == 18 || s == 26) begin
      w.rnd_st  = 1'b1;
      w.rnd_idx = 2'((s - 10) >> 3);
    end
    if (s == 32) begin
      w.rnd_out = 1'b1;
      w.commit  = 1'b1;
      w.cond    = COND_OUT;
      w.last    = 1'b1;
    end
    return w;
  endfunction

endpackage

@@ sv/third_order_state_space_filter.sv @@
// Inputs are taken one at a time: a new transaction is accepted only after the
// previous one has passed its output rounding step. The shared 32x33 multiplier
// is used for 30 steps (two per product), plus one accept step, one pipeline drain
// step and one output rounding step, which stalls while the previous result is
// not yet taken.
// Reset (asynchronous, active low) clears the state vector, the configuration
// registers and the output valid flag; the block is ready for input right after.
module third_order_state_space_filter #(
  parameter int SAMPLE_WIDTH = 32,
  parameter int STATE_WIDTH  = 48
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [1:0]                     cfg_index_i,
  input  logic [31:0]                    cfg_data_i,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic signed [SAMPLE_WIDTH-1:0] sample_in_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic signed [SAMPLE_WIDTH-1:0] sample_out_o,
  output logic                           saturated_o
);

  // Configuration registers. The user must write them only while the block is
  // idle, which the block itself does not enforce; the datapath reads them directly.
  logic [1:0] mode_q;
  logic signed [tsf_pkg::COEF_W-1:0] gain_q [3];

  // Output register. The next transaction may be accepted and computed while
  // a result waits here; on the output side the program only stalls on its final step.
  logic out_valid_q;
  logic signed [SAMPLE_WIDTH-1:0] out_sample_q;
  logic out_sat_q;

  tsf_pkg::ctrl_t ctrl;
  tsf_pkg::stat_t stat;
  logic signed [SAMPLE_WIDTH-1:0] dp_sample;
  logic dp_clip;

  always_comb begin
    stat.in_valid = in_valid_i;
    stat.out_free = !out_valid_q || out_ready_i;
  end

  // The sequencer steps through the microprogram: accept, thirty multiply
  // steps with three state roundings interleaved, then the output rounding.
  tsf_sequencer u_seq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .stat_i  (stat),
    .ctrl_o  (ctrl),
    .ready_o (in_ready_o)
  );

  tsf_datapath #(
    .SAMPLE_WIDTH (SAMPLE_WIDTH),
    .STATE_WIDTH  (STATE_WIDTH)
  ) u_dp (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctrl_i   (ctrl),
    .sample_i (sample_in_i),
    .mode_i   (mode_q),
    .gain_i   (gain_q),
    .sample_o (dp_sample),
    .clip_o   (dp_clip)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= '0;
      gain_q <= '{default: '0};
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        tsf_pkg::REG_RATE_MODE:  mode_q    <= cfg_data_i[1:0];
        tsf_pkg::REG_GAIN_ONE:   gain_q[0] <= cfg_data_i;
        tsf_pkg::REG_GAIN_TWO:   gain_q[1] <= cfg_data_i;
        tsf_pkg::REG_GAIN_THREE: gain_q[2] <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (ctrl.rnd_out) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl.rnd_out) begin
      out_sample_q <= dp_sample;
      out_sat_q    <= dp_clip;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign sample_out_o = out_sample_q;
  assign saturated_o  = out_sat_q;

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("input accepted twice in a row");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl.rnd_out |-> (!out_valid_q || out_ready_i))
    else $error("result written over one not yet taken");

endmodule

@@ sv/tsf_sequencer.sv @@
module tsf_sequencer (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  tsf_pkg::stat_t  stat_i,
  output tsf_pkg::ctrl_t  ctrl_o,
  output logic            ready_o
);

  logic [tsf_pkg::STEP_W-1:0] step_q, step_d;
  tsf_pkg::ctrl_t word;
  logic go;

  always_comb begin
    word = tsf_pkg::ucode(step_q);
    case (word.cond)
      tsf_pkg::COND_NONE: go = 1'b1;
      tsf_pkg::COND_IN:   go = stat_i.in_valid;
      tsf_pkg::COND_OUT:  go = stat_i.out_free;
      default:            go = 1'b0;
    endcase
  end

  // A step whose condition fails jumps to itself and issues no action.
  always_comb begin
    if (!go) begin
      step_d = step_q;
    end else if (word.last) begin
      step_d = '0;
    end else begin
      step_d = step_q + 1'b1;
    end
    ctrl_o  = go ? word : '0;
    ready_o = word.load;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= '0;
    end else begin
      step_q <= step_d;
    end
  end

  a_step_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_q < tsf_pkg::STEP_W'(tsf_pkg::NUM_STEPS))
    else $error("step counter left the program");

  a_load_advances: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_o.load |=> (step_q == tsf_pkg::STEP_W'(1)))
    else $error("accepted transaction did not start the program");

endmodule

@@ sv/tsf_datapath.sv @@
module tsf_datapath #(
  parameter int SAMPLE_WIDTH = 32,
  parameter int STATE_WIDTH  = 48
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  tsf_pkg::ctrl_t                 ctrl_i,
  input  logic signed [SAMPLE_WIDTH-1:0] sample_i,
  input  logic [1:0]                     mode_i,
  input  logic signed [tsf_pkg::COEF_W-1:0] gain_i [3],
  output logic signed [SAMPLE_WIDTH-1:0] sample_o,
  output logic                           clip_o
);

  localparam int OPW  = tsf_pkg::OP_W;
  localparam int HW   = tsf_pkg::HALF_W;
  localparam int ACCW = tsf_pkg::ACC_W;

  localparam logic signed [ACCW-1:0] ST_HALF  = ACCW'(1) << 30;
  localparam logic signed [ACCW-1:0] OUT_HALF = ACCW'(1) << 39;
  localparam logic signed [STATE_WIDTH-1:0]  ST_MAX  = {1'b0, {(STATE_WIDTH-1){1'b1}}};
  localparam logic signed [STATE_WIDTH-1:0]  ST_MIN  = {1'b1, {(STATE_WIDTH-1){1'b0}}};
  localparam logic signed [SAMPLE_WIDTH-1:0] OUT_MAX = {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
  localparam logic signed [SAMPLE_WIDTH-1:0] OUT_MIN = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};

  logic signed [OPW-1:0]          ux_q;
  logic signed [STATE_WIDTH-1:0]  x_q [3];
  logic signed [STATE_WIDTH-1:0]  nx_q [3];
  logic signed [tsf_pkg::PROD_W-1:0] prod_q, prod_d;
  logic pv_q, phi_q, pclr_q;
  logic signed [ACCW-1:0] acc_q, acc_d, addend;
  logic clip_q;

  logic signed [tsf_pkg::COEF_W-1:0] coef;
  logic signed [OPW-1:0]  op;
  logic signed [HW:0]     opm;
  logic signed [ACCW-1:0] st_sum, st_sh, y_sum, y_sh;
  logic signed [STATE_WIDTH-1:0] st_val;
  logic st_clip, y_clip;

  always_comb begin
    if (ctrl_i.src < tsf_pkg::SRC_GAIN0) begin
      coef = tsf_pkg::coef_pick(mode_i, ctrl_i.src);
    end else begin
      case (ctrl_i.src)
        tsf_pkg::SRC_GAIN0: coef = gain_i[0];
        tsf_pkg::SRC_GAIN1: coef = gain_i[1];
        default:            coef = gain_i[2];
      endcase
    end
    case (ctrl_i.opnd)
      tsf_pkg::OPND_X0: op = OPW'(x_q[0]);
      tsf_pkg::OPND_X1: op = OPW'(x_q[1]);
      tsf_pkg::OPND_X2: op = OPW'(x_q[2]);
      tsf_pkg::OPND_UX: op = ux_q;
      tsf_pkg::OPND_N0: op = OPW'(nx_q[0]);
      tsf_pkg::OPND_N1: op = OPW'(nx_q[1]);
      tsf_pkg::OPND_N2: op = OPW'(nx_q[2]);
      default:          op = '0;
    endcase
    // The low half enters as an unsigned value, the high half carries the sign.
    opm    = ctrl_i.hi ? {op[OPW-1], op[OPW-1:HW]} : {1'b0, op[HW-1:0]};
    prod_d = coef * opm;
  end

  always_comb begin
    addend = phi_q ? (ACCW'(prod_q) <<< HW) : ACCW'(prod_q);
    acc_d  = (pclr_q ? '0 : acc_q) + addend;

    st_sum  = acc_q + ST_HALF;
    st_sh   = st_sum >>> 31;
    st_clip = (st_sh != ACCW'(signed'(st_sh[STATE_WIDTH-1:0])));
    st_val  = st_clip ? (st_sh[ACCW-1] ? ST_MIN : ST_MAX) : st_sh[STATE_WIDTH-1:0];

    y_sum  = acc_q + OUT_HALF;
    y_sh   = y_sum >>> 40;
    y_clip = (y_sh != ACCW'(signed'(y_sh[SAMPLE_WIDTH-1:0])));
    sample_o = y_clip ? (y_sh[ACCW-1] ? OUT_MIN : OUT_MAX) : y_sh[SAMPLE_WIDTH-1:0];
    clip_o   = clip_q | y_clip;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pv_q   <= 1'b0;
      phi_q  <= 1'b0;
      pclr_q <= 1'b0;
      x_q    <= '{default: '0};
    end else begin
      pv_q   <= ctrl_i.mul;
      phi_q  <= ctrl_i.hi;
      pclr_q <= ctrl_i.clr;
      if (ctrl_i.commit) begin
        x_q <= nx_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      ux_q   <= OPW'(sample_i) <<< 16;
      clip_q <= 1'b0;
    end else if (ctrl_i.rnd_st) begin
      clip_q <= clip_q | st_clip;
    end
    if (ctrl_i.mul) begin
      prod_q <= prod_d;
    end
    if (pv_q) begin
      acc_q <= acc_d;
    end
    if (ctrl_i.rnd_st) begin
      nx_q[ctrl_i.rnd_idx] <= st_val;
    end
  end

  a_commit_drained: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_i.commit |-> !pv_q)
    else $error("state committed while a product was still pending");

endmodule

@@ sim/tsf_result_checker.sv @@
`timescale 1ns / 100ps

module tsf_result_checker #(
  parameter int SAMPLE_WIDTH = 32,
  parameter int STATE_WIDTH  = 48
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cfg_we_i,
  input  logic [1:0]              cfg_index_i,
  input  logic [31:0]             cfg_data_i,
  input  logic                    in_valid_i,
  input  logic                    in_ready_i,
  input  logic [SAMPLE_WIDTH-1:0] sample_in_i,
  input  logic                    out_valid_i,
  input  logic                    out_ready_i,
  input  logic [SAMPLE_WIDTH-1:0] sample_out_i,
  input  logic                    saturated_i,
  output int                      error_count_o,
  output int                      pending_o
);

  typedef logic signed [127:0] acc_t;

  typedef struct packed {
    logic [SAMPLE_WIDTH-1:0] sample_out;
    logic                    saturated;
  } filter_out_t;

  // a11 a12 a13 a21 a22 a23 a31 a32 a33 b1 b2 b3 per rate, signed Q1.31.
  localparam int COEF_TABLE [3][12] = '{
    '{1332077980, -594464280, -692973453,
      692973453, 2025051432, -149468381,
      74734191, 421220917, 2137152718,
      346486726, 74734191, 5165465},
    '{1977404063, -127074237, -164972575,
      164972575, 2142376638, -6689612,
      3344806, 85831094, 2147393847,
      82486288, 3344806, 44900},
    '{2104641354, -32103988, -42520892,
      42520892, 2147162246, -426637,
      213318, 21473765, 2147482223,
      21260446, 213318, 712}
  };

  tsf_pkg::rate_e          rate_mode_q;
  logic signed [31:0]      gain_q [3];
  logic signed [STATE_WIDTH-1:0] x_state [3];
  filter_out_t             expected_q [$];

  // Round half up by dropping shift bits, then clip to width signed bits.
  function automatic acc_t round_clip(input acc_t sum, input int shift, input int width,
                                      inout logic clip);
    acc_t r;
    acc_t top;
    acc_t bot;
    r = (sum + (acc_t'(1) <<< (shift - 1))) >>> shift;
    top = (acc_t'(1) <<< (width - 1)) - acc_t'(1);
    bot = -top - acc_t'(1);
    if (r > top) begin
      clip = 1'b1;
      r = top;
    end else if (r < bot) begin
      clip = 1'b1;
      r = bot;
    end
    return r;
  endfunction

  // One sample through the filter: state update, then the weighted output.
  function automatic filter_out_t advance_filter(input logic signed [SAMPLE_WIDTH-1:0] u);
    acc_t        ux;
    acc_t        acc;
    acc_t        c;
    acc_t        xv;
    acc_t        y;
    acc_t        nx [3];
    int          tab;
    logic        clip;
    filter_out_t r;
    clip = 1'b0;
    tab = (rate_mode_q == tsf_pkg::RATE_SPARE) ? int'(tsf_pkg::RATE_HUNDRED)
                                               : int'(rate_mode_q);
    ux = u;
    ux = ux <<< 16;
    for (int i = 0; i < 3; i++) begin
      c = COEF_TABLE[tab][9 + i];
      acc = c * ux;
      for (int j = 0; j < 3; j++) begin
        c = COEF_TABLE[tab][3 * i + j];
        xv = x_state[j];
        acc = acc + c * xv;
      end
      nx[i] = round_clip(acc, 31, STATE_WIDTH, clip);
    end
    acc = '0;
    for (int i = 0; i < 3; i++) begin
      x_state[i] = nx[i][STATE_WIDTH-1:0];
      c = gain_q[i];
      acc = acc + c * nx[i];
    end
    y = round_clip(acc, 40, SAMPLE_WIDTH, clip);
    r.sample_out = y[SAMPLE_WIDTH-1:0];
    r.saturated = clip;
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    filter_out_t want;
    if (!rst_ni) begin
      rate_mode_q = tsf_pkg::RATE_FIVE;
      for (int i = 0; i < 3; i++) begin
        gain_q[i] = '0;
        x_state[i] = '0;
      end
      expected_q.delete();
      error_count_o = 0;
      pending_o = 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          tsf_pkg::REG_RATE_MODE:  rate_mode_q = tsf_pkg::rate_e'(cfg_data_i[1:0]);
          tsf_pkg::REG_GAIN_ONE:   gain_q[0] = cfg_data_i;
          tsf_pkg::REG_GAIN_TWO:   gain_q[1] = cfg_data_i;
          tsf_pkg::REG_GAIN_THREE: gain_q[2] = cfg_data_i;
          default: ;
        endcase
      end
      if (out_valid_i && out_ready_i) begin
        if (expected_q.size() == 0) begin
          error_count_o++;
          $display("%0t: unexpected result: expected none, actual sample_out %h saturated %b",
                   $time, sample_out_i, saturated_i);
        end else begin
          want = expected_q.pop_front();
          if (sample_out_i !== want.sample_out) begin
            error_count_o++;
            $display("%0t: sample_out mismatch: expected %h, actual %h",
                     $time, want.sample_out, sample_out_i);
          end
          if (saturated_i !== want.saturated) begin
            error_count_o++;
            $display("%0t: saturated mismatch: expected %b, actual %b",
                     $time, want.saturated, saturated_i);
          end
        end
      end
      if (in_valid_i && in_ready_i) begin
        expected_q.push_back(advance_filter(sample_in_i));
      end
      pending_o = expected_q.size();
    end
  end

endmodule

@@ sim/tb_third_order_state_space_filter.sv @@
`timescale 1ns / 100ps

module tb_third_order_state_space_filter;

  localparam int SAMPLE_WIDTH = 32;
  localparam int STATE_WIDTH  = 48;
  // Settling time after the last result, before the next register writes.
  localparam int SETTLE_CYCLES = 40;
  // Longest correct stretch without a transaction is the receiver hold-off below
  // plus one item time and a long random stall; the limit is several times that.
  localparam int HOLD_CYCLES   = 300;
  localparam int STALL_LIMIT   = 3000;
  localparam int PHASE_ITEMS   = 105;
  localparam int NUM_PHASES    = 8;

  logic                    clk_i = 1'b0;
  logic                    rst_ni = 1'b0;
  logic                    cfg_we = 1'b0;
  logic [1:0]              cfg_index = tsf_pkg::REG_RATE_MODE;
  logic [31:0]             cfg_data = '0;
  logic                    in_valid = 1'b0;
  logic                    in_ready;
  logic [SAMPLE_WIDTH-1:0] sample_in = '0;
  logic                    out_valid;
  logic                    out_ready = 1'b0;
  logic [SAMPLE_WIDTH-1:0] sample_out;
  logic                    saturated;

  int error_count;
  int pending;

  // Idle percentages for each side; changed per phase by the stimulus process.
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  // Raised by the stimulus process, cleared by the receiver once the hold-off is over.
  logic hold_off_req = 1'b0;

  // State of the step generator: a level that is repeated for a run of samples.
  logic [31:0] step_level = '0;
  int          step_left = 0;

  int stall_cycles = 0;

  // Corner samples: zero, both extremes, smallest steps and alternating bit patterns.
  logic [31:0] corner_samples [15] = '{
    32'h0000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
    32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
    32'h0000_0001, 32'hFFFF_FFFF, 32'h0001_0000, 32'hFFFF_0000,
    32'h5555_5555, 32'hAAAA_AAAA
  };

  always #6 clk_i = ~clk_i;

  third_order_state_space_filter #(
    .SAMPLE_WIDTH(SAMPLE_WIDTH),
    .STATE_WIDTH (STATE_WIDTH)
  ) u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .sample_in_i (sample_in),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .sample_out_o(sample_out),
    .saturated_o (saturated)
  );

  tsf_result_checker #(
    .SAMPLE_WIDTH(SAMPLE_WIDTH),
    .STATE_WIDTH (STATE_WIDTH)
  ) u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we),
    .cfg_index_i  (cfg_index),
    .cfg_data_i   (cfg_data),
    .in_valid_i   (in_valid),
    .in_ready_i   (in_ready),
    .sample_in_i  (sample_in),
    .out_valid_i  (out_valid),
    .out_ready_i  (out_ready),
    .sample_out_i (sample_out),
    .saturated_i  (saturated),
    .error_count_o(error_count),
    .pending_o    (pending)
  );

  // Offers one sample and returns at the falling edge after its transaction.
  // A gap, if drawn, lowers valid before the new sample appears, so valid is
  // never dropped while an item is pending.
  task automatic send_sample(input logic [31:0] value);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk_i);
    end
    in_valid = 1'b1;
    sample_in = value;
    do @(posedge clk_i); while (!in_ready);
    @(negedge clk_i);
  endtask

  // Waits until every expected result has arrived, then lets the block settle
  // so that register writes land while it is idle.
  task automatic drain_results();
    in_valid = 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  // Writes all four registers on consecutive cycles. The rate mode carries random
  // upper bits, which the block has to ignore.
  task automatic load_settings(input tsf_pkg::rate_e mode, input logic [31:0] g1,
                               input logic [31:0] g2, input logic [31:0] g3);
    cfg_we = 1'b1;
    cfg_index = tsf_pkg::REG_RATE_MODE;
    cfg_data = ($urandom & 32'hFFFF_FFFC) | 32'(mode);
    @(negedge clk_i);
    cfg_index = tsf_pkg::REG_GAIN_ONE;
    cfg_data = g1;
    @(negedge clk_i);
    cfg_index = tsf_pkg::REG_GAIN_TWO;
    cfg_data = g2;
    @(negedge clk_i);
    cfg_index = tsf_pkg::REG_GAIN_THREE;
    cfg_data = g3;
    @(negedge clk_i);
    cfg_we = 1'b0;
  endtask

  // Gains: mostly moderate weights within twice unity either way (unity is 2^24 in Q8.24), with zero,
  // both extremes and fully random values mixed in to drive the output into
  // saturation.
  function automatic logic [31:0] pick_gain();
    logic [31:0] g;
    case ($urandom_range(7))
      0: g = $urandom;
      1: g = 32'h7FFF_FFFF;
      2: g = 32'h8000_0000;
      3: g = 32'h0000_0000;
      default: g = $urandom_range(32'h03FF_FFFF) - 32'h0200_0000;
    endcase
    return g;
  endfunction

  // Samples: most come as steps, a level held for a run, which is what the
  // filter sees in use; the rest are random, small, or extreme values.
  function automatic logic [31:0] pick_sample();
    int roll;
    roll = $urandom_range(99);
    if (step_left > 0) begin
      step_left--;
      return step_level;
    end
    if (roll < 30) begin
      step_level = roll[0] ? $urandom : $urandom_range(32'h01FF_FFFF) - 32'h0100_0000;
      step_left = $urandom_range(30, 5);
      return step_level;
    end else if (roll < 55) begin
      return $urandom;
    end else if (roll < 85) begin
      return $urandom_range(32'h001F_FFFF) - 32'h0010_0000;
    end
    case ($urandom_range(3))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return 32'h0000_0000;
      default: return 32'hFFFF_FFFF;
    endcase
  endfunction

  // Receiver: ready is redrawn at every falling edge. On request it holds off
  // for a long stretch so that the block fills up and has to stall its input.
  initial begin
    forever begin
      @(negedge clk_i);
      if (hold_off_req) begin
        out_ready = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk_i);
        hold_off_req = 1'b0;
      end
      out_ready = ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Watchdog: counts cycles without any transaction or register write.
  always @(posedge clk_i) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_we) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles >= STALL_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial begin
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Directed part. First plain unity-like weights on the rate five table with
    // the corner samples, including long runs at both extremes.
    send_idle_pct = 32;
    recv_idle_pct = 51;
    load_settings(tsf_pkg::RATE_FIVE, 32'h0100_0000, 32'hFF00_0000, 32'h0080_0000);
    foreach (corner_samples[i]) send_sample(corner_samples[i]);
    drain_results();

    // Then the spare rate code, which must behave as rate one hundred, with
    // extreme weights so that the output clips in both directions. The state
    // is carried over from the items above.
    load_settings(tsf_pkg::RATE_SPARE, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
    repeat (3) send_sample(32'h7FFF_FFFF);
    repeat (3) send_sample(32'h8000_0000);
    send_sample(32'h0000_0001);
    drain_results();

    // Random part. Each phase gets its own register setting, cycling through
    // all four rate codes; idling is sender-light first, then receiver-light,
    // then none at all.
    for (int phase = 0; phase < NUM_PHASES; phase++) begin
      if (phase < 3) begin
        send_idle_pct = 32;
        recv_idle_pct = 51;
      end else if (phase < 6) begin
        send_idle_pct = 51;
        recv_idle_pct = 32;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      load_settings(tsf_pkg::rate_e'(phase % 4), pick_gain(), pick_gain(), pick_gain());
      // One long receiver hold-off while the sender keeps offering samples.
      if (phase == 1) hold_off_req = 1'b1;
      repeat (PHASE_ITEMS) send_sample(pick_sample());
      drain_results();
    end

    if (error_count == 0 && pending == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

@@ files.f @@
sv/tsf_pkg.sv
sv/tsf_sequencer.sv
sv/tsf_datapath.sv
sv/third_order_state_space_filter.sv
sim/tsf_result_checker.sv
sim/tb_third_order_state_space_filter.sv
